>>> sv/ddmo_pkg.sv
// Shared types, constants and arithmetic helpers for the odometry and move sequencer block.
package ddmo_pkg;

	localparam int CORDIC_STEPS_DEF = 16;

	// Datapath widths.
	localparam int NUM_W  = 51;
	localparam int DEN_W  = 24;
	localparam int REM_W  = DEN_W + 1;
	localparam int MA_W   = 33;
	localparam int MB_W   = 26;
	localparam int PROD_W = MA_W + MB_W;
	localparam int ANG_W  = 20;
	localparam int HEAD_W = 19;
	localparam int IN_W   = 80;
	localparam int OUT_W  = 152;

	// Angle constants in Q16.16.
	localparam int PI_Q      = 205887;
	localparam int TWO_PI_Q  = 411774;
	localparam int HALF_PI_Q = 102944;
	localparam int CORDIC_GAIN = 39797;

	localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

	typedef enum logic [1:0] {
		KIND_TICK      = 2'd0,
		KIND_ROTATE    = 2'd1,
		KIND_TRANSLATE = 2'd2,
		KIND_STOP      = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MS_STOP      = 2'd0,
		MS_ROTATE    = 2'd1,
		MS_TRANSLATE = 2'd2
	} motion_t;

	typedef enum logic [2:0] {
		CFG_ROT_PREC  = 3'd0,
		CFG_TR_PREC   = 3'd1,
		CFG_ROT_SPEED = 3'd2,
		CFG_TR_SPEED  = 3'd3,
		CFG_PERIMETER = 3'd4,
		CFG_CENTER    = 3'd5,
		CFG_RATIO     = 3'd6,
		CFG_SAMPLE    = 3'd7
	} cfg_idx_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_BANG,
		OP_REM,
		OP_WCD,
		OP_D2,
		OP_DROTM,
		OP_SUMM,
		OP_DTR,
		OP_DIV1,
		OP_DIV2,
		OP_T2,
		OP_XM,
		OP_X,
		OP_Y,
		OP_DIV3,
		OP_HEAD,
		OP_OUT
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_BANG,
		S_REM,
		S_WCD,
		S_D2,
		S_DROTM,
		S_SUMM,
		S_DTR,
		S_WDIV1,
		S_WDIV2,
		S_T2,
		S_WCOR,
		S_X,
		S_Y,
		S_WDIV3,
		S_WWRAP,
		S_OUT
	} state_t;

	typedef struct packed {
		op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic cor_busy;
		logic wrap_busy;
		logic out_free;
	} dp_stat_t;

	// Arctangent of 2^-i in Q16.16.
	function automatic logic [15:0] atan_q(input logic [4:0] idx);
		logic [15:0] r;
		case (idx)
			5'd0:    r = 16'd51472;
			5'd1:    r = 16'd30385;
			5'd2:    r = 16'd16055;
			5'd3:    r = 16'd8150;
			5'd4:    r = 16'd4091;
			5'd5:    r = 16'd2047;
			5'd6:    r = 16'd1024;
			5'd7:    r = 16'd512;
			5'd8:    r = 16'd256;
			5'd9:    r = 16'd128;
			5'd10:   r = 16'd64;
			5'd11:   r = 16'd32;
			5'd12:   r = 16'd16;
			5'd13:   r = 16'd8;
			5'd14:   r = 16'd4;
			5'd15:   r = 16'd2;
			5'd16:   r = 16'd1;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

	// Clip to the 32-bit signed range.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > SAT_MAX)
			r = 32'sh7FFF_FFFF;
		else if (v < SAT_MIN)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic ovf32(input logic signed [63:0] v);
		return (v > SAT_MAX) || (v < SAT_MIN);
	endfunction

	// Division of a product by 2^k, truncated toward zero.
	function automatic logic signed [PROD_W-1:0] trunc_shr(input logic signed [PROD_W-1:0] p,
		input int unsigned k);
		logic signed [PROD_W-1:0] bias;
		logic signed [PROD_W-1:0] r;
		bias = (PROD_W'(1) << k) - PROD_W'(1);
		if (p < 0)
			r = (p + bias) >>> k;
		else
			r = p >>> k;
		return r;
	endfunction

endpackage

>>> sv/ddmo_div.sv
// Bit-serial signed divider, quotient truncated toward zero.
module ddmo_div
	import ddmo_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic [DEN_W-1:0]        den,
	output logic                    done,
	output logic signed [NUM_W:0]   quo
);

	localparam int CNT_W = $clog2(NUM_W);

	logic [NUM_W-1:0] quo_q;
	logic [REM_W-1:0] acc_q;
	logic [DEN_W-1:0] den_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [NUM_W-1:0] num_abs;
	logic [REM_W-1:0] trial;
	logic             fits;

	assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign trial   = {acc_q[DEN_W-1:0], quo_q[NUM_W-1]};
	assign fits    = trial >= {1'b0, den_q};

	// One quotient bit per cycle, most significant first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(NUM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num_abs;
			acc_q <= '0;
			den_q <= den;
			neg_q <= num[NUM_W-1];
		end else if (busy_q) begin
			acc_q <= fits ? trial - {1'b0, den_q} : trial;
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

>>> sv/ddmo_dp.sv
// Datapath: configuration, motion and pose state, shared multiplier, divider and CORDIC.
module ddmo_dp
	import ddmo_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	output dp_stat_t         stat,
	input  logic [1:0]       in_kind,
	input  logic [IN_W-1:0]  in_data,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [23:0]      cfg_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] out_data
);

	localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam logic signed [ANG_W-1:0] PI_A      = ANG_W'(PI_Q);
	localparam logic signed [ANG_W-1:0] TWO_PI_A  = ANG_W'(TWO_PI_Q);
	localparam logic signed [ANG_W-1:0] HALF_PI_A = ANG_W'(HALF_PI_Q);
	localparam logic signed [ANG_W-1:0] GAIN_A    = ANG_W'(CORDIC_GAIN);
	localparam logic [32:0]             TWO_PI_W  = 33'(TWO_PI_Q);
	// 2*pi times 2^12 is the largest multiple the heading sum can need.
	localparam logic [3:0]              WRAP_TOP  = 4'd12;

	// Configuration registers.
	logic [15:0] rot_prec_q, tr_prec_q, sample_q;
	logic [23:0] rot_speed_q, tr_speed_q, perim_q, center_q;
	logic [17:0] ratio_q;

	// Persistent state.
	logic [1:0]               ms_q;
	logic signed [31:0]       rem_ang_q, rem_dist_q, pose_x_q, pose_y_q;
	logic signed [HEAD_W-1:0] head_q;

	// Per-tick working registers.
	logic signed [23:0]       d1_q, d2in_q;
	logic signed [25:0]       d2_q;
	logic signed [24:0]       v_q, w_q;
	logic                     dir_pos_q, dir_neg_q;
	logic                     sel_rot_q;
	logic signed [48:0]       wcd_q;
	logic signed [NUM_W-1:0]  drotnum_q;
	logic signed [31:0]       dtr_q, t1_q, t2_q;
	logic                     ov_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                     out_valid_q;
	logic [OUT_W-1:0]         out_data_q;

	// CORDIC state.
	logic signed [ANG_W-1:0] cx_q, cy_q, cz_q;
	logic                    cneg_q, cbusy_q;
	logic [CNT_W-1:0]        ccnt_q;

	// Heading wrap state.
	logic [32:0]             wm_q;
	logic                    wneg_q, wbusy_q;
	logic [3:0]              wcnt_q;
	logic [32:0]             wsub;

	logic signed [MA_W-1:0]   mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic                     div_start;
	logic signed [NUM_W-1:0]  div_num;
	logic [DEN_W-1:0]         div_den;
	logic                     div_done;
	logic signed [NUM_W:0]    div_quo;
	logic [23:0]              wp_eff, cd_eff, bvmax;
	logic signed [26:0]       sum27, diff27;
	logic signed [NUM_W-1:0]  vsh;
	logic signed [31:0]       quo_sat;
	logic                     quo_ov;
	logic signed [32:0]       hsum;
	logic signed [ANG_W-1:0]  cos_w, sin_w, sx, sy, at, hz, wr;
	logic signed [32:0]       rem_cur, prec_cur;
	logic signed [63:0]       step64, rem_new, tq16, tq17, nx, ny;
	kind_t                    kind;

	assign kind    = kind_t'(in_kind);
	assign wp_eff  = (perim_q == '0) ? 24'd1 : perim_q;
	assign cd_eff  = (center_q == '0) ? 24'd1 : center_q;
	assign bvmax   = (ms_q == MS_ROTATE) ? rot_speed_q : tr_speed_q;
	assign sum27   = 27'(d1_q) + 27'(d2_q);
	assign diff27  = 27'(d2_q) - 27'(d1_q);
	assign vsh     = NUM_W'(v_q) <<< 16;
	assign quo_sat = sat32(64'(div_quo));
	assign quo_ov  = ovf32(64'(div_quo));
	assign hsum    = 33'(head_q) + 33'(quo_sat);
	assign cos_w   = cneg_q ? -cx_q : cx_q;
	assign sin_w   = cneg_q ? -cy_q : cy_q;
	assign sx      = cx_q >>> ccnt_q;
	assign sy      = cy_q >>> ccnt_q;
	assign at      = ANG_W'(atan_q(5'(ccnt_q)));
	assign hz      = ANG_W'(head_q);
	assign wsub    = TWO_PI_W << wcnt_q;
	assign rem_cur  = (ms_q == MS_ROTATE) ? 33'(rem_ang_q) : 33'(rem_dist_q);
	assign prec_cur = (ms_q == MS_ROTATE) ? $signed({17'd0, rot_prec_q})
	                                      : $signed({17'd0, tr_prec_q});
	assign step64  = 64'(trunc_shr(prod_q, 16));
	assign rem_new = sel_rot_q
		? (dir_neg_q ? 64'(rem_ang_q) + step64 : 64'(rem_ang_q) - step64)
		: (dir_neg_q ? 64'(rem_dist_q) + step64 : 64'(rem_dist_q) - step64);
	assign tq16    = 64'(trunc_shr(prod_q, 16));
	assign tq17    = 64'(trunc_shr(prod_q, 17));
	assign nx      = 64'(pose_x_q) + tq16;
	assign ny      = 64'(pose_y_q) + tq16;

	// Give the reduced magnitude the sign of the sum, then wrap into (-pi, pi].
	always_comb begin
		wr = ANG_W'(wm_q);
		if (wneg_q)
			wr = -wr;
		if (wr < 0)
			wr = wr + TWO_PI_A;
		if (wr > PI_A)
			wr = wr - TWO_PI_A;
	end

	// Operand selection for the multiplier and the divider.
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (cmd.op)
			OP_BANG: begin
				mul_a = $signed(MA_W'(bvmax));
				mul_b = $signed(MB_W'(sample_q));
			end
			OP_REM: begin
				mul_a = MA_W'(w_q);
				mul_b = $signed(MB_W'(cd_eff));
			end
			OP_WCD: begin
				mul_a = MA_W'(d2in_q);
				mul_b = $signed(MB_W'(ratio_q));
			end
			OP_DROTM: begin
				mul_a     = MA_W'(diff27);
				mul_b     = $signed(MB_W'(wp_eff));
				div_start = 1'b1;
				div_num   = vsh - NUM_W'(wcd_q);
				div_den   = wp_eff;
			end
			OP_SUMM: begin
				mul_a = MA_W'(sum27);
				mul_b = $signed(MB_W'(wp_eff));
			end
			OP_DIV1: begin
				div_start = 1'b1;
				div_num   = vsh + NUM_W'(wcd_q);
				div_den   = wp_eff;
			end
			OP_DIV2: begin
				mul_a     = MA_W'(quo_sat);
				mul_b     = $signed(MB_W'(ratio_q));
				div_start = 1'b1;
				div_num   = drotnum_q;
				div_den   = cd_eff;
			end
			OP_XM: begin
				mul_a = MA_W'(dtr_q);
				mul_b = MB_W'(cos_w);
			end
			OP_X: begin
				mul_a = MA_W'(dtr_q);
				mul_b = MB_W'(sin_w);
			end
			default: begin
			end
		endcase
	end

	ddmo_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_prec_q  <= 16'd655;
			tr_prec_q   <= 16'd66;
			rot_speed_q <= 24'd65536;
			tr_speed_q  <= 24'd19661;
			perim_q     <= 24'd13744;
			center_q    <= 24'd9830;
			ratio_q     <= 18'd65536;
			sample_q    <= 16'd655;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ROT_PREC:  rot_prec_q  <= cfg_data[15:0];
				CFG_TR_PREC:   tr_prec_q   <= cfg_data[15:0];
				CFG_ROT_SPEED: rot_speed_q <= cfg_data;
				CFG_TR_SPEED:  tr_speed_q  <= cfg_data;
				CFG_PERIMETER: perim_q     <= cfg_data;
				CFG_CENTER:    center_q    <= cfg_data;
				CFG_RATIO:     ratio_q     <= cfg_data[17:0];
				CFG_SAMPLE:    sample_q    <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Motion and pose state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q       <= MS_STOP;
			rem_ang_q  <= '0;
			rem_dist_q <= '0;
			pose_x_q   <= '0;
			pose_y_q   <= '0;
			head_q     <= '0;
		end else begin
			case (cmd.op)
				OP_ACCEPT: begin
					case (kind)
						KIND_ROTATE: begin
							rem_ang_q <= in_data[31:0];
							ms_q      <= MS_ROTATE;
						end
						KIND_TRANSLATE: begin
							rem_dist_q <= in_data[31:0];
							ms_q       <= MS_TRANSLATE;
						end
						KIND_STOP: ms_q <= MS_STOP;
						default: begin
						end
					endcase
				end
				OP_BANG: begin
					if (ms_q != MS_STOP && !(rem_cur > prec_cur) && !(rem_cur < -prec_cur))
						ms_q <= MS_STOP;
				end
				OP_REM: begin
					if (dir_pos_q || dir_neg_q) begin
						if (sel_rot_q)
							rem_ang_q <= sat32(rem_new);
						else
							rem_dist_q <= sat32(rem_new);
					end
				end
				OP_X:    pose_x_q <= sat32(nx);
				OP_Y:    pose_y_q <= sat32(ny);
				OP_HEAD: head_q   <= wr[HEAD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Per-tick working registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (cmd.op)
			OP_ACCEPT: begin
				d1_q   <= in_data[55:32];
				d2in_q <= in_data[79:56];
				ov_q   <= 1'b0;
			end
			OP_BANG: begin
				dir_pos_q <= (ms_q != MS_STOP) && (rem_cur > prec_cur);
				dir_neg_q <= (ms_q != MS_STOP) && !(rem_cur > prec_cur) && (rem_cur < -prec_cur);
				sel_rot_q <= (ms_q == MS_ROTATE);
				v_q <= '0;
				w_q <= '0;
				if (ms_q == MS_ROTATE) begin
					if (rem_cur > prec_cur)
						w_q <= $signed({1'b0, bvmax});
					else if (rem_cur < -prec_cur)
						w_q <= -$signed({1'b0, bvmax});
				end else if (ms_q == MS_TRANSLATE) begin
					if (rem_cur > prec_cur)
						v_q <= $signed({1'b0, bvmax});
					else if (rem_cur < -prec_cur)
						v_q <= -$signed({1'b0, bvmax});
				end
			end
			OP_REM: begin
				if (dir_pos_q || dir_neg_q)
					ov_q <= ov_q | ovf32(rem_new);
			end
			OP_WCD:  wcd_q     <= 49'(trunc_shr(prod_q, 1));
			OP_D2:   d2_q      <= 26'(trunc_shr(prod_q, 16));
			OP_SUMM: drotnum_q <= prod_q[NUM_W-1:0];
			OP_DTR: begin
				dtr_q <= sat32(tq17);
				ov_q  <= ov_q | ovf32(tq17);
			end
			OP_DIV1: begin
				t1_q <= quo_sat;
				ov_q <= ov_q | quo_ov;
			end
			OP_DIV2: ov_q <= ov_q | quo_ov;
			OP_T2: begin
				t2_q <= sat32(tq16);
				ov_q <= ov_q | ovf32(tq16);
			end
			OP_X:    ov_q <= ov_q | ovf32(nx);
			OP_Y:    ov_q <= ov_q | ovf32(ny);
			OP_DIV3: ov_q <= ov_q | quo_ov;
			OP_OUT: begin
				out_data_q <= {2'b00, ov_q, ms_q, head_q, pose_y_q, pose_x_q, t2_q, t1_q};
			end
			default: begin
			end
		endcase
	end

	// Result word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.op == OP_OUT)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// CORDIC: one micro-rotation per cycle on the heading held before this tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cbusy_q <= 1'b0;
			ccnt_q  <= '0;
		end else if (cmd.op == OP_DROTM) begin
			cbusy_q <= 1'b1;
			ccnt_q  <= '0;
		end else if (cbusy_q) begin
			ccnt_q <= ccnt_q + CNT_W'(1);
			if (ccnt_q == CNT_W'(CORDIC_STEPS - 1))
				cbusy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_DROTM) begin
			cx_q <= GAIN_A;
			cy_q <= '0;
			if (hz > HALF_PI_A) begin
				cz_q   <= hz - PI_A;
				cneg_q <= 1'b1;
			end else if (hz < -HALF_PI_A) begin
				cz_q   <= hz + PI_A;
				cneg_q <= 1'b1;
			end else begin
				cz_q   <= hz;
				cneg_q <= 1'b0;
			end
		end else if (cbusy_q) begin
			if (cz_q >= 0) begin
				cx_q <= cx_q - sy;
				cy_q <= cy_q + sx;
				cz_q <= cz_q - at;
			end else begin
				cx_q <= cx_q + sy;
				cy_q <= cy_q - sx;
				cz_q <= cz_q + at;
			end
		end
	end

	// Heading wrap: reduce the magnitude of the heading sum modulo 2*pi by
	// compare and subtract of 2*pi * 2^j, j from 12 down to 0, one step per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wbusy_q <= 1'b0;
			wcnt_q  <= '0;
		end else if (cmd.op == OP_DIV3) begin
			wbusy_q <= 1'b1;
			wcnt_q  <= WRAP_TOP;
		end else if (wbusy_q) begin
			wcnt_q <= wcnt_q - 4'd1;
			if (wcnt_q == 4'd0)
				wbusy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_DIV3) begin
			wm_q   <= hsum[32] ? 33'(-hsum) : 33'(hsum);
			wneg_q <= hsum[32];
		end else if (wbusy_q && (wm_q >= wsub)) begin
			wm_q <= wm_q - wsub;
		end
	end

	assign stat.div_done  = div_done;
	assign stat.cor_busy  = cbusy_q;
	assign stat.wrap_busy = wbusy_q;
	assign stat.out_free  = !out_valid_q || out_ready;
	assign out_valid      = out_valid_q;
	assign out_data       = out_data_q;

endmodule

>>> sv/ddmo_ctrl.sv
// Controller: sequences one tick through the datapath operations.
module ddmo_ctrl
	import ddmo_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_kind,
	input  dp_stat_t   stat,
	output logic       in_ready,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// Next state and operation for the datapath.
	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_ACCEPT;
					if (kind_t'(in_kind) == KIND_TICK)
						state_d = S_BANG;
				end
			end
			S_BANG: begin
				cmd.op  = OP_BANG;
				state_d = S_REM;
			end
			S_REM: begin
				cmd.op  = OP_REM;
				state_d = S_WCD;
			end
			S_WCD: begin
				cmd.op  = OP_WCD;
				state_d = S_D2;
			end
			S_D2: begin
				cmd.op  = OP_D2;
				state_d = S_DROTM;
			end
			S_DROTM: begin
				cmd.op  = OP_DROTM;
				state_d = S_SUMM;
			end
			S_SUMM: begin
				cmd.op  = OP_SUMM;
				state_d = S_DTR;
			end
			S_DTR: begin
				cmd.op  = OP_DTR;
				state_d = S_WDIV1;
			end
			S_WDIV1: begin
				if (stat.div_done) begin
					cmd.op  = OP_DIV1;
					state_d = S_WDIV2;
				end
			end
			S_WDIV2: begin
				if (stat.div_done) begin
					cmd.op  = OP_DIV2;
					state_d = S_T2;
				end
			end
			S_T2: begin
				cmd.op  = OP_T2;
				state_d = S_WCOR;
			end
			S_WCOR: begin
				if (!stat.cor_busy) begin
					cmd.op  = OP_XM;
					state_d = S_X;
				end
			end
			S_X: begin
				cmd.op  = OP_X;
				state_d = S_Y;
			end
			S_Y: begin
				cmd.op  = OP_Y;
				state_d = S_WDIV3;
			end
			S_WDIV3: begin
				if (stat.div_done) begin
					cmd.op  = OP_DIV3;
					state_d = S_WWRAP;
				end
			end
			S_WWRAP: begin
				if (!stat.wrap_busy) begin
					cmd.op  = OP_HEAD;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.op  = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

>>> sv/diff_drive_motion_odometry.sv
// Top level of the differential-drive move sequencer with odometry.
// A rotate, translate or stop word is taken while idle, leaves the block idle and gives
// no result. A tick word runs the bang-bang sequencer, the wheel target conversion and
// the odometry update and gives one result word after three passes through the shared
// bit-serial divider (for both wheel targets and the heading increment) and a 13-step
// compare-and-subtract heading wrap; the CORDIC runs alongside the divider. The next
// word is taken as soon as the result sits in the output register. Configuration
// writes are taken in every cycle.
module diff_drive_motion_odometry
	import ddmo_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// command_amount[31:0], wheel1_delta[55:32], wheel2_delta[79:56]
	input  logic [IN_W-1:0]  s_tdata,
	// kind[1:0]
	input  logic [1:0]       s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// motor1_target[31:0], motor2_target[63:32], pose_x_out[95:64], pose_y_out[127:96],
	// heading_out[146:128], motion_state_out[148:147], overflow[149], zero[151:150]
	output logic [OUT_W-1:0] m_tdata,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [23:0]      cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	ddmo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_kind  (s_tuser),
		.stat     (stat),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	ddmo_dp #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_kind   (s_tuser),
		.in_data   (s_tdata),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

>>> sv/ddmo_chk.sv
// Port-level checks for the odometry block, bound to the top level.
module ddmo_chk
	import ddmo_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic [IN_W-1:0]  s_tdata,
	input logic [1:0]       s_tuser,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic             cfg_valid,
	input logic             cfg_ready,
	input logic [2:0]       cfg_index,
	input logic [23:0]      cfg_data
);

	// A stalled result word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// After a command word the block is ready again in the next cycle.
	a_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && kind_t'(s_tuser) != KIND_TICK |=> s_tready)
		else $error("block busy after a command word");

	// A tick word keeps the block busy.
	a_tick: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && kind_t'(s_tuser) == KIND_TICK |=> !s_tready)
		else $error("block took a word right after a tick");

	// A new result word only comes out of a busy block.
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result word without a tick");

	// Heading and motion state stay in range.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[148:147] <= MS_TRANSLATE
			&& $signed(m_tdata[146:128]) <= 19'sd205887
			&& $signed(m_tdata[146:128]) >= -19'sd205887)
		else $error("result field out of range");

endmodule

bind diff_drive_motion_odometry ddmo_chk u_chk (.*);
